// ===== rtl/ialu_pkg.sv =====
package ialu_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned MUL_DIGIT      = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_POW = 3'd5,
    OP_NEG = 3'd6
  } ialu_op_e;

endpackage

// ===== rtl/integer_alu_div_mod_pow_unit.sv =====
// Channel   Direction  Handshake             Payload
// request   in         in_valid_i/in_stall_o func_i, left_operand_i, right_operand_i
// result    out        out_valid_o/out_stall_i result_value_o, divide_by_zero_o
//
// One request at a time; in_stall_o is high from acceptance until the result is registered.
// Add, sub, negate, zero divisor and trivial power finish without the multiplier or divider.
// Multiply: iterative, using an 8-bit digit multiplier.
// Divide/remainder: one quotient bit per cycle.
// Power: square-and-multiply over the exponent bits, using the digit multiplier.
// A held result stalls completion of the next request; reset clears all state.
module integer_alu_div_mod_pow_unit #(
  parameter int unsigned DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   func_i,
  input  logic signed [DATA_WIDTH-1:0] left_operand_i,
  input  logic signed [DATA_WIDTH-1:0] right_operand_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         divide_by_zero_o
);
  import ialu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_POW_CHECK,
    S_POW_ACC,
    S_POW_SQ,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [2:0]            op_q, op_d;
  logic                  sgn_a_q, sgn_a_d;
  logic                  sgn_b_q, sgn_b_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] sq_q, sq_d;
  logic [DATA_WIDTH-1:0] ex_q, ex_d;
  logic [DATA_WIDTH-1:0] res_q, res_d;
  logic                  dz_q, dz_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_res_q, out_res_d;
  logic                  out_dz_q, out_dz_d;

  logic [DATA_WIDTH-1:0] a_in, b_in, mag_a, mag_b;
  logic                  mul_start, mul_done;
  logic [DATA_WIDTH-1:0] mul_a, mul_b, mul_prod;
  logic                  div_start, div_done;
  logic [DATA_WIDTH-1:0] div_quo, div_rem;

  assign a_in  = left_operand_i;
  assign b_in  = right_operand_i;
  assign mag_a = a_in[DATA_WIDTH-1] ? -a_in : a_in;
  assign mag_b = b_in[DATA_WIDTH-1] ? -b_in : b_in;

  ialu_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_a),
    .mplier_i (mul_b),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  ialu_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_a),
    .divisor_i  (mag_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sgn_a_d     = sgn_a_q;
    sgn_b_d     = sgn_b_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    ex_d        = ex_q;
    res_d       = res_q;
    dz_d        = dz_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_dz_d    = out_dz_q;
    mul_start   = 1'b0;
    mul_a       = acc_q;
    mul_b       = sq_q;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = func_i;
          sgn_a_d = a_in[DATA_WIDTH-1];
          sgn_b_d = b_in[DATA_WIDTH-1];
          dz_d    = 1'b0;
          state_d = S_FINISH;
          case (ialu_op_e'(func_i))
            OP_ADD: res_d = a_in + b_in;
            OP_SUB: res_d = a_in - b_in;
            OP_NEG: res_d = -a_in;
            OP_MUL: begin
              mul_start = 1'b1;
              mul_a     = a_in;
              mul_b     = b_in;
              state_d   = S_MUL;
            end
            OP_DIV, OP_MOD: begin
              if (b_in == '0) begin
                res_d = '0;
                dz_d  = 1'b1;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_POW: begin
              if (b_in == '0) begin
                res_d = DATA_WIDTH'(1);
              end else if (b_in == DATA_WIDTH'(1) || b_in[DATA_WIDTH-1]) begin
                res_d = a_in;
              end else begin
                acc_d   = DATA_WIDTH'(1);
                sq_d    = a_in;
                ex_d    = b_in;
                state_d = S_POW_CHECK;
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          res_d   = mul_prod;
          state_d = S_FINISH;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_DIV) begin
            res_d = (sgn_a_q != sgn_b_q) ? -div_quo : div_quo;
          end else begin
            res_d = sgn_a_q ? -div_rem : div_rem;
          end
          state_d = S_FINISH;
        end
      end
      S_POW_CHECK: begin
        if (ex_q == '0) begin
          res_d   = acc_q;
          state_d = S_FINISH;
        end else if (ex_q[0]) begin
          mul_start = 1'b1;
          state_d   = S_POW_ACC;
        end else begin
          mul_start = 1'b1;
          mul_a     = sq_q;
          state_d   = S_POW_SQ;
        end
      end
      S_POW_ACC: begin
        if (mul_done) begin
          acc_d = mul_prod;
          if (ex_q[DATA_WIDTH-1:1] == '0) begin
            res_d   = mul_prod;
            state_d = S_FINISH;
          end else begin
            mul_start = 1'b1;
            mul_a     = sq_q;
            state_d   = S_POW_SQ;
          end
        end
      end
      S_POW_SQ: begin
        if (mul_done) begin
          sq_d    = mul_prod;
          ex_d    = ex_q >> 1;
          state_d = S_POW_CHECK;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_dz_d    = dz_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      sgn_a_q     <= 1'b0;
      sgn_b_q     <= 1'b0;
      acc_q       <= '0;
      sq_q        <= '0;
      ex_q        <= '0;
      res_q       <= '0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_dz_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sgn_a_q     <= sgn_a_d;
      sgn_b_q     <= sgn_b_d;
      acc_q       <= acc_d;
      sq_q        <= sq_d;
      ex_q        <= ex_d;
      res_q       <= res_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
      out_dz_q    <= out_dz_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_res_q;
  assign divide_by_zero_o = out_dz_q;

endmodule

// ===== rtl/ialu_mul.sv =====
module ialu_mul #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] mcand_i,
  input  logic [DATA_WIDTH-1:0] mplier_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] prod_o
);
  import ialu_pkg::*;

  localparam int unsigned STEPS = (DATA_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0]       mcand_q, mcand_d;
  logic [DATA_WIDTH-1:0]       mplier_q, mplier_d;
  logic [DATA_WIDTH-1:0]       acc_q, acc_d;
  logic [DATA_WIDTH+MUL_DIGIT-1:0] part;

  assign part = mcand_q * mplier_q[MUL_DIGIT-1:0];

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      acc_d    = '0;
    end else if (busy_q) begin
      acc_d    = acc_q + part[DATA_WIDTH-1:0];
      mcand_d  = mcand_q << MUL_DIGIT;
      mplier_d = mplier_q >> MUL_DIGIT;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      acc_q    <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/ialu_div.sv =====
module ialu_div #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DATA_WIDTH);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dvs_q, dvs_d;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;

  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DATA_WIDTH]) begin
        rem_d = trial[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DATA_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== bench/integer_alu_div_mod_pow_unit_tb.sv =====
`timescale 1ns / 100ps

module integer_alu_div_mod_pow_unit_tb;
  import ialu_pkg::*;

  localparam int unsigned W = DATA_WIDTH_DEF;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [W-1:0] MAX_S = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_S = {1'b1, {(W-1){1'b0}}};

  localparam int RANDOM_ITEMS     = 1100;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT   = 5000;

  typedef struct packed {
    logic [W-1:0] value;
    logic         dz;
  } alu_result_t;

  typedef struct packed {
    logic [2:0]   fn;
    logic [W-1:0] a;
    logic [W-1:0] b;
    bit           typed;
    logic [W-1:0] value;
    logic         dz;
  } alu_request_t;

  localparam int N_DIRECTED = 26;
  localparam alu_request_t DIRECTED [N_DIRECTED] = '{
    '{OP_ADD,    MAX_S,  1,     1, MIN_S, 0},
    '{OP_ADD,    MIN_S,  MIN_S, 1, 0,     0},
    '{OP_ADD,    -1,     1,     0, 0,     0},
    '{OP_SUB,    MIN_S,  1,     1, MAX_S, 0},
    '{OP_SUB,    0,      MIN_S, 1, MIN_S, 0},
    '{OP_MUL,    MAX_S,  MAX_S, 1, 1,     0},
    '{OP_MUL,    MIN_S,  -1,    1, MIN_S, 0},
    '{OP_MUL,    -3,     5,     0, 0,     0},
    '{OP_DIV,    1234,   0,     1, 0,     1},
    '{OP_MOD,    MIN_S,  0,     1, 0,     1},
    '{OP_DIV,    MIN_S,  -1,    1, MIN_S, 0},
    '{OP_MOD,    MIN_S,  -1,    1, 0,     0},
    '{OP_DIV,    -7,     2,     0, 0,     0},
    '{OP_MOD,    -7,     2,     0, 0,     0},
    '{OP_MOD,    7,      -2,    0, 0,     0},
    '{OP_DIV,    MAX_S,  MIN_S, 0, 0,     0},
    '{OP_POW,    0,      0,     1, 1,     0},
    '{OP_POW,    MIN_S,  0,     1, 1,     0},
    '{OP_POW,    -5,     1,     1, -5,    0},
    '{OP_POW,    3,      MIN_S, 1, 3,     0},
    '{OP_POW,    3,      5,     0, 0,     0},
    '{OP_POW,    2,      31,    0, 0,     0},
    '{OP_POW,    -1,     MAX_S, 0, 0,     0},
    '{OP_NEG,    MIN_S,  0,     1, MIN_S, 0},
    '{OP_NEG,    MAX_S,  -1,    0, 0,     0},
    '{OP_UNUSED, MAX_S,  MAX_S, 1, 0,     0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          func_i;
  logic signed [W-1:0] left_operand_i;
  logic signed [W-1:0] right_operand_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic signed [W-1:0] result_value_o;
  logic                divide_by_zero_o;

  alu_result_t expected_results [$];
  int          fail_count   = 0;
  int          results_seen = 0;
  int          idle_cycles  = 0;

  integer_alu_div_mod_pow_unit #(
    .DATA_WIDTH(W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .left_operand_i  (left_operand_i),
    .right_operand_i (right_operand_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  function automatic alu_result_t predict_alu(logic [2:0] fn, logic [W-1:0] a,
                                              logic [W-1:0] b);
    alu_result_t r;
    logic [W-1:0] ua, ub, q, acc, sq, ex;
    r = '0;
    case (fn)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == '0) begin
          r.dz = 1'b1;
        end else begin
          ua = a[W-1] ? -a : a;
          ub = b[W-1] ? -b : b;
          if (fn == OP_DIV) begin
            q = ua / ub;
            r.value = (a[W-1] ^ b[W-1]) ? -q : q;
          end else begin
            q = ua % ub;
            r.value = a[W-1] ? -q : q;
          end
        end
      end
      OP_POW: begin
        if (b == '0) begin
          r.value = 1;
        end else if (b == 1 || b[W-1]) begin
          r.value = a;
        end else begin
          acc = 1;
          sq  = a;
          ex  = b;
          while (ex != '0) begin
            if (ex[0]) acc = acc * sq;
            sq = sq * sq;
            ex = ex >> 1;
          end
          r.value = acc;
        end
      end
      OP_NEG: r.value = -a;
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return MIN_S;
      4: return MAX_S;
      5, 6: return W'($urandom_range(40));
      7: return -W'($urandom_range(40));
      default: return W'($urandom);
    endcase
  endfunction

  task automatic offer_request(input alu_request_t req);
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    func_i          = req.fn;
    left_operand_i  = req.a;
    right_operand_i = req.b;
    do @(posedge clk_i); while (in_stall_o);
    if (req.typed) begin
      expected_results.push_back(alu_result_t'{req.value, req.dz});
    end else begin
      expected_results.push_back(predict_alu(req.fn, req.a, req.b));
    end
  endtask

  task automatic drop_valid(input int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    alu_result_t want;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request pending: result_value %0d divide_by_zero %0b",
                 result_value_o, divide_by_zero_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_value_o !== want.value) begin
            $error("result_value: expected %0d, actual %0d", $signed(want.value),
                   result_value_o);
            fail_count++;
          end
          if (divide_by_zero_o !== want.dz) begin
            $error("divide_by_zero: expected %0b, actual %0b", want.dz, divide_by_zero_o);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("** integer_alu_div_mod_pow_unit: FAILED **");
    $finish;
  end

  initial begin
    int  mode;
    int  mode_left;
    int  period;
    bit  long_done;
    mode        = 0;
    mode_left   = 0;
    period      = 2;
    long_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_done && results_seen >= 300) begin
        long_done   = 1'b1;
        out_stall_i = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(2);
        mode_left = $urandom_range(20, 200);
        period    = $urandom_range(2, 9);
      end
      mode_left--;
      case (mode)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(99) < 40);
        default: out_stall_i = ((mode_left % period) < (period / 2));
      endcase
    end
  end

  initial begin
    alu_request_t req;
    int           burst_left;
    int           gap;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    func_i          = OP_ADD;
    left_operand_i  = '0;
    right_operand_i = '0;
    burst_left      = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) offer_request(DIRECTED[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        drop_valid(1);
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0
            : $urandom_range(1, ($urandom_range(4) == 0) ? 60 : 8);
        if (gap > 0) drop_valid(gap);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;

      req = '0;
      case ($urandom_range(15))
        0, 1:       req.fn = OP_ADD;
        2, 3:       req.fn = OP_SUB;
        4, 5:       req.fn = OP_MUL;
        6, 7:       req.fn = OP_DIV;
        8, 9:       req.fn = OP_MOD;
        10, 11, 12: req.fn = OP_POW;
        13, 14:     req.fn = OP_NEG;
        default:    req.fn = OP_UNUSED;
      endcase
      req.a = pick_operand();
      if (req.fn == OP_POW) begin
        case ($urandom_range(7))
          0, 1, 2, 3, 4: req.b = W'($urandom_range(12));
          5:             req.b = W'($urandom_range(W - 1));
          6:             req.b = W'($urandom);
          default:       req.b = pick_operand();
        endcase
      end else begin
        req.b = pick_operand();
      end
      offer_request(req);
    end

    drop_valid(1);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** integer_alu_div_mod_pow_unit: PASSED **");
    end else begin
      $display("** integer_alu_div_mod_pow_unit: FAILED **");
    end
    $finish;
  end

endmodule
